// File: rtl/stpm_pkg.sv
// ----------------------------------------------------------------------------
// stpm_pkg
// Types, register codes and colour ramp tables of the scalar-to-colour mapper.
// ----------------------------------------------------------------------------
package stpm_pkg;

   typedef struct packed {
      logic signed [31:0] sample_value;
      logic               sample_finite;
   } req_data_type;

   typedef struct packed {
      logic [7:0] red_level;
      logic [7:0] green_level;
      logic [7:0] blue_level;
   } rsp_data_type;

   typedef enum logic [1:0] {
      CSR_STRETCH_LOW  = 2'd0,
      CSR_STRETCH_HIGH = 2'd1,
      CSR_PALETTE      = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PAL_GREY    = 2'd0,
      PAL_VIRIDIS = 2'd1,
      PAL_ENERGY  = 2'd2,
      PAL_JET     = 2'd3
   } palette_type;

   typedef enum logic [1:0] {
      KIND_ZERO   = 2'd0,
      KIND_FULL   = 2'd1,
      KIND_DIVIDE = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] diff;
      logic [31:0] span;
   } work_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

   localparam logic signed [31:0] STRETCH_LOW_RESET  = 32'sd0;
   localparam logic signed [31:0] STRETCH_HIGH_RESET = 32'sd65536;
   localparam logic [3:0]         LAST_SEGMENT       = 4'd14;

   localparam logic [7:0] RAMP_VIRIDIS [48] = '{
      8'd68,  8'd1,   8'd84,  8'd72,  8'd26,  8'd108, 8'd71,  8'd47,  8'd125,
      8'd65,  8'd68,  8'd135, 8'd57,  8'd86,  8'd140, 8'd49,  8'd104, 8'd142,
      8'd42,  8'd120, 8'd142, 8'd35,  8'd136, 8'd142, 8'd31,  8'd152, 8'd139,
      8'd34,  8'd168, 8'd132, 8'd53,  8'd183, 8'd121, 8'd85,  8'd198, 8'd103,
      8'd122, 8'd209, 8'd81,  8'd165, 8'd219, 8'd54,  8'd210, 8'd226, 8'd27,
      8'd253, 8'd231, 8'd37};

   localparam logic [7:0] RAMP_ENERGY [48] = '{
      8'd48,  8'd18,  8'd59,  8'd65,  8'd69,  8'd171, 8'd74,  8'd117, 8'd240,
      8'd70,  8'd160, 8'd253, 8'd49,  8'd198, 8'd223, 8'd34,  8'd225, 8'd190,
      8'd48,  8'd243, 8'd140, 8'd96,  8'd253, 8'd89,  8'd146, 8'd255, 8'd52,
      8'd188, 8'd243, 8'd42,  8'd222, 8'd220, 8'd49,  8'd247, 8'd187, 8'd49,
      8'd254, 8'd145, 8'd38,  8'd241, 8'd99,  8'd22,  8'd216, 8'd60,  8'd9,
      8'd165, 8'd20,  8'd2};

   localparam logic [7:0] RAMP_JET [48] = '{
      8'd0,   8'd0,   8'd143, 8'd0,   8'd0,   8'd207, 8'd0,   8'd0,   8'd255,
      8'd0,   8'd63,  8'd255, 8'd0,   8'd127, 8'd255, 8'd0,   8'd191, 8'd255,
      8'd38,  8'd255, 8'd214, 8'd93,  8'd255, 8'd159, 8'd159, 8'd255, 8'd93,
      8'd214, 8'd255, 8'd38,  8'd255, 8'd208, 8'd0,   8'd255, 8'd145, 8'd0,
      8'd255, 8'd81,  8'd0,   8'd255, 8'd18,  8'd0,   8'd207, 8'd0,   8'd0,
      8'd143, 8'd0,   8'd0};

   function automatic logic [7:0] anchor_level(palette_type pal, logic [3:0] idx,
                                                logic [1:0] ch);
      logic [5:0] pos;
      logic [7:0] lvl;
      pos = 6'(idx) * 6'd3 + 6'(ch);
      unique case (pal)
         PAL_ENERGY: lvl = RAMP_ENERGY[pos];
         PAL_JET:    lvl = RAMP_JET[pos];
         default:    lvl = RAMP_VIRIDIS[pos];
      endcase
      return lvl;
   endfunction

endpackage

// File: rtl/scalar_to_colour_pixel_mapper.sv
// ----------------------------------------------------------------------------
// scalar_to_colour_pixel_mapper
// Maps signed fixed-point samples to RGB pixels through a grey or colour ramp.
// ----------------------------------------------------------------------------
// Accepts one sample per clock and returns one pixel per sample, in order, at
// a sustained rate of one per cycle while rsp_ready is high. A sample passes
// through the front register, the queue, NORM_BITS + 1 divider stages, the
// segment stage and the output register; the restoring divider produces one
// quotient bit per stage. The stretch and palette registers are read as items
// pass, so write them only while the block is idle.
module scalar_to_colour_pixel_mapper #(
   parameter int SAMPLE_FRAC_BITS = 16,
   parameter int NORM_BITS        = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  stpm_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output stpm_pkg::rsp_data_type rsp_data,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_wdata
);
   import stpm_pkg::*;

   logic signed [31:0] stretch_low_ff;
   logic signed [31:0] stretch_high_ff;
   palette_type        palette_ff;
   queue_status_type   queue_status;
   logic               push, pop, out_grey;
   work_type           push_data, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         stretch_low_ff  <= STRETCH_LOW_RESET;
         stretch_high_ff <= STRETCH_HIGH_RESET;
         palette_ff      <= PAL_VIRIDIS;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_STRETCH_LOW:  stretch_low_ff  <= csr_wdata;
            CSR_STRETCH_HIGH: stretch_high_ff <= csr_wdata;
            CSR_PALETTE:      palette_ff      <= palette_type'(csr_wdata[1:0]);
            default:          ;
         endcase
      end
   end

   stpm_front #(.SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .stretch_low  (stretch_low_ff),
      .stretch_high (stretch_high_ff),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   stpm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .status    (queue_status),
      .head      (head)
   );

   stpm_back #(.NORM_BITS(NORM_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head         (head),
      .pop          (pop),
      .palette      (palette_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .out_grey     (out_grey)
   );

   // reset empties the queue and the output
   assert property (@(posedge clock) reset |=> !rsp_valid && !queue_status.valid)
      else $error("pipeline not empty after reset");

   // grey pixels have equal channels
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_grey |->
         rsp_data.red_level == rsp_data.green_level &&
         rsp_data.green_level == rsp_data.blue_level)
      else $error("grey pixel with unequal channels");

   // nothing is popped from an empty queue
   assert property (@(posedge clock) disable iff (reset) pop |-> queue_status.valid)
      else $error("pop from empty queue");

endmodule

// File: rtl/stpm_front.sv
// ----------------------------------------------------------------------------
// stpm_front
// Takes samples, applies the stretch limits and classifies each sample as
// zero, full scale or needing a division.
// ----------------------------------------------------------------------------
module stpm_front #(
   parameter int SAMPLE_FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  stpm_pkg::req_data_type     req_data,
   input  logic signed [31:0]         stretch_low,
   input  logic signed [31:0]         stretch_high,
   input  stpm_pkg::queue_status_type queue_status,
   output logic                       push,
   output stpm_pkg::work_type         push_data
);
   import stpm_pkg::*;

   logic               valid_ff, valid_in;
   work_type           work_ff, work_in;
   logic signed [33:0] lo, hi, hi_eff, span, diff;

   assign push      = valid_ff && !queue_status.full;
   assign req_ready = !valid_ff || !queue_status.full;
   assign push_data = work_ff;

   always_comb begin
      lo     = 34'(stretch_low);
      hi     = 34'(stretch_high);
      hi_eff = (hi <= lo) ? lo + (34'sd1 <<< SAMPLE_FRAC_BITS) : hi;
      span   = hi_eff - lo;
      diff   = 34'(req_data.sample_value) - lo;
      work_in.span = span[31:0];
      work_in.diff = diff[31:0];
      priority if (!req_data.sample_finite || diff <= 34'sd0) begin
         work_in.kind = KIND_ZERO;
      end else if (diff >= span) begin
         work_in.kind = KIND_FULL;
      end else begin
         work_in.kind = KIND_DIVIDE;
      end
      valid_in = (req_valid && req_ready) || (valid_ff && queue_status.full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         work_ff <= work_in;
      end
   end

endmodule

// File: rtl/stpm_queue.sv
// ----------------------------------------------------------------------------
// stpm_queue
// Two-entry queue between the classifying front and the mapping back.
// ----------------------------------------------------------------------------
module stpm_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  stpm_pkg::work_type         push_data,
   input  logic                       pop,
   output stpm_pkg::queue_status_type status,
   output stpm_pkg::work_type         head
);
   import stpm_pkg::*;

   work_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign status.full  = (count_ff == 2'd2);
   assign status.valid = (count_ff != 2'd0);
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/stpm_back.sv
// ----------------------------------------------------------------------------
// stpm_back
// Pipelined restoring divider, one quotient bit per stage, followed by the
// segment split and the per-channel ramp interpolation (grey palette: t scaled by 255).
// ----------------------------------------------------------------------------
module stpm_back #(
   parameter int NORM_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  stpm_pkg::queue_status_type queue_status,
   input  stpm_pkg::work_type         head,
   output logic                       pop,
   input  stpm_pkg::palette_type      palette,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output stpm_pkg::rsp_data_type     rsp_data,
   output logic                       out_grey
);
   import stpm_pkg::*;

   localparam int TW = NORM_BITS + 1;

   logic                 advance;
   logic                 div_valid_ff [NORM_BITS+1];
   kind_type             div_kind_ff  [NORM_BITS+1];
   logic [31:0]          div_rem_ff   [NORM_BITS+1];
   logic [31:0]          div_span_ff  [NORM_BITS+1];
   logic [NORM_BITS-1:0] div_quot_ff  [NORM_BITS+1];
   logic [31:0]          rem_in       [NORM_BITS];
   logic [NORM_BITS-1:0] quot_in      [NORM_BITS];
   logic [32:0]          shifted      [NORM_BITS];
   logic                 ge           [NORM_BITS];

   logic              t_in;
   logic [TW-1:0]     t_val;
   logic [TW+3:0]     s_val;
   logic [3:0]        seg_in;
   logic [TW+3:0]     f_wide;

   logic              seg_valid_ff;
   palette_type       seg_pal_ff;
   logic [TW-1:0]     seg_t_ff;
   logic [3:0]        seg_idx_ff;
   logic [TW-1:0]     seg_f_ff;

   logic              rsp_valid_ff;
   rsp_data_type      rsp_data_ff, rsp_data_in;
   logic              grey_ff;

   logic [TW+8:0]     grey_sum;
   logic [7:0]        lvl_a [3];
   logic [7:0]        lvl_b [3];
   logic signed [8:0] delta [3];
   logic signed [TW+10:0] num [3];
   logic [7:0]        chan [3];

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign pop       = advance && queue_status.valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_grey  = grey_ff;
   assign t_in      = div_valid_ff[NORM_BITS];

   always_comb begin
      for (int k = 0; k < NORM_BITS; k++) begin
         shifted[k] = {div_rem_ff[k], 1'b0};
         ge[k]      = shifted[k] >= {1'b0, div_span_ff[k]};
         rem_in[k]  = ge[k] ? 32'(shifted[k] - {1'b0, div_span_ff[k]})
                            : shifted[k][31:0];
         quot_in[k] = {div_quot_ff[k][NORM_BITS-2:0], ge[k]};
      end
   end

   always_comb begin
      unique case (div_kind_ff[NORM_BITS])
         KIND_ZERO: t_val = '0;
         KIND_FULL: t_val = TW'(1) << NORM_BITS;
         default:   t_val = {1'b0, div_quot_ff[NORM_BITS]};
      endcase
      s_val  = (TW+4)'(t_val) * (TW+4)'(15);
      seg_in = (s_val[TW+3:NORM_BITS] > 5'(LAST_SEGMENT)) ? LAST_SEGMENT
                                                          : s_val[NORM_BITS+3:NORM_BITS];
      f_wide = s_val - ((TW+4)'(seg_in) << NORM_BITS);
   end

   always_comb begin
      grey_sum = (TW+9)'(seg_t_ff) * (TW+9)'(255) + ((TW+9)'(1) << (NORM_BITS-1));
      for (int c = 0; c < 3; c++) begin
         lvl_a[c] = anchor_level(seg_pal_ff, seg_idx_ff, 2'(c));
         lvl_b[c] = anchor_level(seg_pal_ff, seg_idx_ff + 4'd1, 2'(c));
         delta[c] = $signed({1'b0, lvl_b[c]}) - $signed({1'b0, lvl_a[c]});
         num[c]   = ((TW+11)'($signed({1'b0, lvl_a[c]})) <<< NORM_BITS)
                  + (TW+11)'($signed({1'b0, seg_f_ff})) * (TW+11)'(delta[c])
                  + ((TW+11)'(1) <<< (NORM_BITS-1));
         chan[c]  = num[c][NORM_BITS+7:NORM_BITS];
      end
      if (seg_pal_ff == PAL_GREY) begin
         rsp_data_in.red_level   = grey_sum[NORM_BITS+7:NORM_BITS];
         rsp_data_in.green_level = grey_sum[NORM_BITS+7:NORM_BITS];
         rsp_data_in.blue_level  = grey_sum[NORM_BITS+7:NORM_BITS];
      end else begin
         rsp_data_in.red_level   = chan[0];
         rsp_data_in.green_level = chan[1];
         rsp_data_in.blue_level  = chan[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NORM_BITS; k++) begin
            div_valid_ff[k] <= 1'b0;
         end
         seg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         div_valid_ff[0] <= queue_status.valid;
         for (int k = 0; k < NORM_BITS; k++) begin
            div_valid_ff[k+1] <= div_valid_ff[k];
         end
         seg_valid_ff <= t_in;
         rsp_valid_ff <= seg_valid_ff;
      end
      if (advance) begin
         div_kind_ff[0] <= head.kind;
         div_rem_ff[0]  <= head.diff;
         div_span_ff[0] <= head.span;
         div_quot_ff[0] <= '0;
         for (int k = 0; k < NORM_BITS; k++) begin
            div_kind_ff[k+1] <= div_kind_ff[k];
            div_rem_ff[k+1]  <= rem_in[k];
            div_span_ff[k+1] <= div_span_ff[k];
            div_quot_ff[k+1] <= quot_in[k];
         end
         seg_pal_ff  <= palette;
         seg_t_ff    <= t_val;
         seg_idx_ff  <= seg_in;
         seg_f_ff    <= f_wide[TW-1:0];
         rsp_data_ff <= rsp_data_in;
         grey_ff     <= (seg_pal_ff == PAL_GREY);
      end
   end

endmodule
